// ----- src/ubseg_pkg.sv -----
// Shared types and constants for the UTF-8 block shuffle entry generator.
package ubseg_pkg;

  localparam int MaskW       = 15;
  localparam int BlockBytes  = 16;
  localparam int LaneCount   = 8;
  localparam int StageLanes  = 4;
  localparam int PosW        = 5;
  localparam int CountW      = 4;
  localparam int StepW       = 5;

  localparam logic [PosW-1:0]  BlockEnd  = PosW'(BlockBytes);
  localparam logic [PosW-1:0]  Lead3Pos  = PosW'(13);
  localparam logic [StepW-1:0] ErrStep   = StepW'(BlockBytes);

  localparam logic [1:0] Size1 = 2'd1;
  localparam logic [1:0] Size2 = 2'd2;
  localparam logic [1:0] Size3 = 2'd3;

  localparam logic [7:0] HdrLead1  = 8'h80;
  localparam logic [7:0] HdrLead2  = 8'hE0;
  localparam logic [7:0] HdrLead3  = 8'hF0;
  localparam logic [7:0] HdrCont   = 8'hC0;
  localparam logic [7:0] ByteUnused = 8'hFF;

  localparam logic [15:0] Max1     = 16'((1 << 7) - 1);
  localparam logic [15:0] Max2     = 16'((1 << 11) - 1);
  localparam logic [15:0] Max3     = 16'((1 << 15) - 1);
  localparam logic [15:0] MaxError = 16'hFFFF;

  typedef struct packed {
    logic [3:0] start;
    logic [1:0] size;
  } lane_t;

  // Parse state handed from one walk stage to the next.
  typedef struct packed {
    logic                     ok;
    logic [MaskW-1:0]         mask;
    logic [PosW-1:0]          pos;
    logic                     done;
    logic [CountW-1:0]        count;
    lane_t [LaneCount-1:0]    lane;
  } walk_t;

  typedef struct packed {
    logic                pattern_ok;
    logic [63:0]         pair_shuffle_low;
    logic [63:0]         pair_shuffle_high;
    logic [63:0]         third_shuffle;
    logic [StepW-1:0]    source_step;
    logic [StepW-1:0]    dest_step;
    logic [63:0]         header_low;
    logic [63:0]         header_high;
    logic [63:0]         lane_max_low;
    logic [63:0]         lane_max_high;
  } res_t;

  // Size of the character whose lead byte sits at pos (pos below 16).
  function automatic logic [1:0] char_size(input logic [MaskW-1:0] mask,
                                           input logic [3:0] pos);
    logic [MaskW+2:0] ext;
    logic [PosW-1:0]  p1;
    logic [PosW-1:0]  p2;
    ext = {2'b00, mask, 1'b0};
    p1  = {1'b0, pos} + PosW'(1);
    p2  = {1'b0, pos} + PosW'(2);
    if (!ext[p1]) begin
      char_size = Size1;
    end else if (!ext[p2]) begin
      char_size = Size2;
    end else begin
      char_size = Size3;
    end
  endfunction

endpackage

// ----- src/ubseg_in_if.sv -----
// Input channel: one continuation mask per item.
interface ubseg_in_if
  import ubseg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [MaskW-1:0] cont_mask;

  modport source (output valid, output cont_mask, input ready);
  modport sink   (input valid, input cont_mask, output ready);
endinterface

// ----- src/ubseg_out_if.sv -----
// Output channel: one decoder table entry per item.
interface ubseg_out_if
  import ubseg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             pattern_ok;
  logic [63:0]      pair_shuffle_low;
  logic [63:0]      pair_shuffle_high;
  logic [63:0]      third_shuffle;
  logic [StepW-1:0] source_step;
  logic [StepW-1:0] dest_step;
  logic [63:0]      header_low;
  logic [63:0]      header_high;
  logic [63:0]      lane_max_low;
  logic [63:0]      lane_max_high;

  modport source (output valid, output pattern_ok, output pair_shuffle_low,
                  output pair_shuffle_high, output third_shuffle, output source_step,
                  output dest_step, output header_low, output header_high,
                  output lane_max_low, output lane_max_high, input ready);
  modport sink   (input valid, input pattern_ok, input pair_shuffle_low,
                  input pair_shuffle_high, input third_shuffle, input source_step,
                  input dest_step, input header_low, input header_high,
                  input lane_max_low, input lane_max_high, output ready);
endinterface

// ----- src/utf8_block_shuffle_entry_gen.sv -----
// Top level of the UTF-8 block shuffle entry generator.
//
// Takes the continuation-byte mask of one 16-byte UTF-8 block per item and
// returns its decoder table entry: pair and third-byte shuffle indices, source
// and destination steps, per-byte header masks and per-lane maximum values.
// A run of three continuation bytes gives the error entry (pattern_ok low).
// Throughput is one item per clock while the result side does not stall.
// The item passes four register stages, the first loaded at the
// accepting edge: the input register with the three-in-a-row check, two walk
// stages that each parse up to four characters (one short chain of narrow
// add/compare steps per character), and the assembly stage that builds the
// 64-bit words in the output register. Each stage holds its item while the
// next one stalls, so backpressure on the result side never drops or repeats
// an item. MAX_LANES (1 to 8) caps the number of characters decoded per block.
module utf8_block_shuffle_entry_gen
  import ubseg_pkg::*;
#(
  parameter int MAX_LANES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ubseg_in_if.sink            in_i,
  ubseg_out_if.source         res_o
);

  // Input register stage.
  logic             s1_valid_q;
  logic [MaskW-1:0] s1_mask_q;
  logic             s1_ready;
  walk_t            s1_walk;

  // Walk stages.
  logic  w0_valid;
  logic  w0_ready;
  walk_t w0_data;
  logic  w1_valid;
  logic  w1_ready;
  walk_t w1_data;

  // Output stage.
  logic  asm_ready;
  res_t  out_data;

  assign s1_ready   = !s1_valid_q || w0_ready;
  assign in_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_mask_q <= in_i.cont_mask;
    end
  end

  // Flag any run of three continuation bytes; seed the walk at byte 0.
  always_comb begin
    s1_walk       = '0;
    s1_walk.ok    = ~|(s1_mask_q & (s1_mask_q >> 1) & (s1_mask_q >> 2));
    s1_walk.mask  = s1_mask_q;
    s1_walk.pos   = '0;
    s1_walk.done  = 1'b0;
    s1_walk.count = '0;
  end

  ubseg_walk #(
    .LaneBase (0),
    .MaxLanes (MAX_LANES)
  ) u_walk0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .ready_o (w0_ready),
    .data_i  (s1_walk),
    .valid_o (w0_valid),
    .ready_i (w1_ready),
    .data_o  (w0_data)
  );

  ubseg_walk #(
    .LaneBase (StageLanes),
    .MaxLanes (MAX_LANES)
  ) u_walk1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (w0_valid),
    .ready_o (w1_ready),
    .data_i  (w0_data),
    .valid_o (w1_valid),
    .ready_i (asm_ready),
    .data_o  (w1_data)
  );

  ubseg_asm u_asm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (w1_valid),
    .ready_o (asm_ready),
    .data_i  (w1_data),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (out_data)
  );

  assign res_o.pattern_ok        = out_data.pattern_ok;
  assign res_o.pair_shuffle_low  = out_data.pair_shuffle_low;
  assign res_o.pair_shuffle_high = out_data.pair_shuffle_high;
  assign res_o.third_shuffle     = out_data.third_shuffle;
  assign res_o.source_step       = out_data.source_step;
  assign res_o.dest_step         = out_data.dest_step;
  assign res_o.header_low        = out_data.header_low;
  assign res_o.header_high       = out_data.header_high;
  assign res_o.lane_max_low      = out_data.lane_max_low;
  assign res_o.lane_max_high     = out_data.lane_max_high;

endmodule

// ----- src/ubseg_walk.sv -----
// Walk stage: parse up to four characters of the block and register the state.
module ubseg_walk
  import ubseg_pkg::*;
#(
  parameter int LaneBase = 0,
  parameter int MaxLanes = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  walk_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output walk_t data_o
);

  walk_t           st;
  logic [1:0]      sz;
  logic [PosW-1:0] fin;
  logic            valid_q;
  walk_t           data_q;

  always_comb begin
    st  = data_i;
    sz  = Size1;
    fin = '0;
    for (int l = 0; l < StageLanes; l++) begin
      if (LaneBase + l < MaxLanes) begin
        if (!st.done && st.pos < BlockEnd) begin
          sz  = char_size(st.mask, st.pos[3:0]);
          fin = st.pos + PosW'(sz);
          // Take the char if the next lead is in the block, or a 3-byte char ends it.
          if (fin < BlockEnd || (st.pos == Lead3Pos && sz == Size3)) begin
            st.lane[3'(LaneBase + l)].start = st.pos[3:0];
            st.lane[3'(LaneBase + l)].size  = sz;
            st.count = st.count + CountW'(1);
            st.pos   = fin;
          end else begin
            st.done = 1'b1;
          end
        end else begin
          st.done = 1'b1;
        end
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= st;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- src/ubseg_asm.sv -----
// Assembly stage: build shuffle, header and lane-max words into the output register.
module ubseg_asm
  import ubseg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  walk_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  data_o
);

  logic [LaneCount-1:0]            lane_on;
  logic [LaneCount-1:0][PosW-1:0]  lane_fin;
  logic [LaneCount-1:0][3:0]       lane_last;
  logic [2*LaneCount-1:0][7:0]     shab;
  logic [LaneCount-1:0][7:0]       shc;
  logic [BlockBytes-1:0][7:0]      hdr;
  logic [LaneCount-1:0][15:0]      maxv;
  res_t                            res;
  logic                            valid_q;
  res_t                            res_q;

  always_comb begin
    for (int i = 0; i < LaneCount; i++) begin
      lane_on[i]   = CountW'(i) < data_i.count;
      lane_fin[i]  = PosW'(data_i.lane[i].start) + PosW'(data_i.lane[i].size);
      lane_last[i] = 4'(lane_fin[i] - PosW'(1));
    end
  end

  always_comb begin
    shab = {(2*LaneCount){ByteUnused}};
    shc  = {LaneCount{ByteUnused}};
    hdr  = '0;
    maxv = {LaneCount{Max3}};
    for (int i = 0; i < LaneCount; i++) begin
      if (lane_on[i]) begin
        shab[2*i] = {4'b0000, lane_last[i]};
        if (data_i.lane[i].size != Size1) begin
          shab[2*i+1] = {4'b0000, lane_last[i] - 4'd1};
        end
        if (data_i.lane[i].size == Size3) begin
          shc[i] = {4'b0000, data_i.lane[i].start};
        end
        case (data_i.lane[i].size)
          Size1:   maxv[i] = Max1;
          Size2:   maxv[i] = Max2;
          default: maxv[i] = Max3;
        endcase
      end
    end
    for (int b = 0; b < BlockBytes; b++) begin
      for (int i = 0; i < LaneCount; i++) begin
        if (lane_on[i] && 4'(b) >= data_i.lane[i].start && PosW'(b) < lane_fin[i]) begin
          if (4'(b) == data_i.lane[i].start) begin
            case (data_i.lane[i].size)
              Size1:   hdr[b] = HdrLead1;
              Size2:   hdr[b] = HdrLead2;
              default: hdr[b] = HdrLead3;
            endcase
          end else begin
            hdr[b] = HdrCont;
          end
        end
      end
    end

    res.pattern_ok        = data_i.ok;
    res.pair_shuffle_low  = shab[7:0];
    res.pair_shuffle_high = shab[15:8];
    res.third_shuffle     = shc;
    res.source_step       = StepW'(data_i.pos);
    res.dest_step         = StepW'({data_i.count, 1'b0});
    res.header_low        = hdr[7:0];
    res.header_high       = hdr[15:8];
    res.lane_max_low      = maxv[3:0];
    res.lane_max_high     = maxv[7:4];

    // Error entry overrides everything.
    if (!data_i.ok) begin
      res.pair_shuffle_low  = '1;
      res.pair_shuffle_high = '1;
      res.third_shuffle     = '1;
      res.source_step       = ErrStep;
      res.dest_step         = '0;
      res.header_low        = '1;
      res.header_high       = '1;
      res.lane_max_low      = {4{MaxError}};
      res.lane_max_high     = {4{MaxError}};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      res_q <= res;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = res_q;

endmodule

// ----- src/ubseg_chk.sv -----
// Port-level checker for the UTF-8 block shuffle entry generator, with its bind.
module ubseg_chk
  import ubseg_pkg::*;
#(
  parameter int MaxLanes = 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic             pattern_ok_i,
  input logic [63:0]      pair_shuffle_low_i,
  input logic [63:0]      header_low_i,
  input logic [StepW-1:0] source_step_i,
  input logic [StepW-1:0] dest_step_i
);

  // Hold a stalled result.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(pair_shuffle_low_i)
      && $stable(source_step_i) && $stable(dest_step_i))
    else $error("stalled result changed");

  a_error_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !pattern_ok_i |-> source_step_i == ErrStep && dest_step_i == '0
      && header_low_i == '1)
    else $error("malformed error entry");

  a_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && pattern_ok_i |-> !dest_step_i[0] && dest_step_i != '0
      && dest_step_i <= StepW'(2 * MaxLanes) && source_step_i <= ErrStep
      && {1'b0, source_step_i} >= ({1'b0, dest_step_i} >> 1))
    else $error("steps out of range");

  // The first char always decodes.
  a_lane0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && pattern_ok_i |-> pair_shuffle_low_i[7:0] != ByteUnused
      && header_low_i[7:0] != 8'h00)
    else $error("lane 0 not decoded");

endmodule

bind utf8_block_shuffle_entry_gen ubseg_chk #(
  .MaxLanes (MAX_LANES)
) u_ubseg_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .res_valid_i        (res_o.valid),
  .res_ready_i        (res_o.ready),
  .pattern_ok_i       (res_o.pattern_ok),
  .pair_shuffle_low_i (res_o.pair_shuffle_low),
  .header_low_i       (res_o.header_low),
  .source_step_i      (res_o.source_step),
  .dest_step_i        (res_o.dest_step)
);

// ----- sim/utf8_block_shuffle_entry_gen_tb.sv -----
// Self-checking testbench for the UTF-8 block shuffle entry generator.
module utf8_block_shuffle_entry_gen_tb;
  import ubseg_pkg::*;

  // Decode cap handed to the block; the predictor uses the same value.
  localparam int LaneCap = 8;

  logic clk_i;
  logic rst_ni;

  ubseg_in_if  in_ch ();
  ubseg_out_if res_ch ();

  utf8_block_shuffle_entry_gen #(
    .MAX_LANES(LaneCap)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .res_o (res_ch.source)
  );

  // Entries predicted for accepted masks, oldest first.
  res_t pending_entries[$];
  int   mismatches;
  // When set, both sides run back to back without idle cycles.
  bit   calm;

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  // Predict the decoder entry of one continuation mask.
  function automatic res_t predict_entry(input logic [MaskW-1:0] m);
    res_t        r;
    logic [7:0]  pair_b[BlockBytes];
    logic [7:0]  third_b[LaneCount];
    logic [7:0]  hdr_b[BlockBytes];
    logic [15:0] lmax[LaneCount];
    logic [17:0] cont;
    int          pos;
    int          lanes;
    int          consumed;
    int          s;
    int          sz;
    int          e;
    bit          ok;
    bit          stop;
    // Byte 0 is always a lead; bytes 16 and 17 lie beyond the block.
    cont = {2'b00, m, 1'b0};
    ok = 1'b1;
    for (int k = 0; k <= 12; k++) begin
      if (m[k +: 3] == 3'b111) begin
        ok = 1'b0;
      end
    end
    if (!ok) begin
      // Three continuation bytes in a row: flood everything with the error entry.
      r.pattern_ok        = 1'b0;
      r.pair_shuffle_low  = '1;
      r.pair_shuffle_high = '1;
      r.third_shuffle     = '1;
      r.source_step       = ErrStep;
      r.dest_step         = '0;
      r.header_low        = '1;
      r.header_high       = '1;
      r.lane_max_low      = {4{MaxError}};
      r.lane_max_high     = {4{MaxError}};
      return r;
    end
    for (int i = 0; i < BlockBytes; i++) begin
      pair_b[i] = ByteUnused;
      hdr_b[i]  = 8'h00;
    end
    for (int i = 0; i < LaneCount; i++) begin
      third_b[i] = ByteUnused;
      lmax[i]    = Max3;
    end
    pos      = 0;
    lanes    = 0;
    consumed = 0;
    stop     = 1'b0;
    while (pos < BlockBytes && lanes < LaneCap && !stop) begin
      s  = pos;
      sz = 1;
      while (sz < 3 && s + sz < BlockBytes && cont[s + sz]) begin
        sz++;
      end
      e = s + sz;
      // Keep the char only if the next lead is inside the block, or it is
      // the three-byte char that ends exactly at the block end.
      if (!(e < BlockBytes || (s == int'(Lead3Pos) && sz == 3))) begin
        stop = 1'b1;
      end else begin
        pair_b[2 * lanes] = 8'(e - 1);
        if (sz >= 2) begin
          pair_b[2 * lanes + 1] = 8'(e - 2);
        end
        if (sz == 3) begin
          third_b[lanes] = 8'(s);
        end
        hdr_b[s] = (sz == 1) ? HdrLead1 : (sz == 2) ? HdrLead2 : HdrLead3;
        for (int j = 1; j < sz; j++) begin
          hdr_b[s + j] = HdrCont;
        end
        lmax[lanes] = (sz == 1) ? Max1 : (sz == 2) ? Max2 : Max3;
        lanes++;
        consumed = e;
        pos      = e;
      end
    end
    r.pattern_ok  = 1'b1;
    r.source_step = StepW'(consumed);
    r.dest_step   = StepW'(2 * lanes);
    for (int i = 0; i < 8; i++) begin
      r.pair_shuffle_low[8 * i +: 8]  = pair_b[i];
      r.pair_shuffle_high[8 * i +: 8] = pair_b[i + 8];
      r.third_shuffle[8 * i +: 8]     = third_b[i];
      r.header_low[8 * i +: 8]        = hdr_b[i];
      r.header_high[8 * i +: 8]       = hdr_b[i + 8];
    end
    for (int i = 0; i < 4; i++) begin
      r.lane_max_low[16 * i +: 16]  = lmax[i];
      r.lane_max_high[16 * i +: 16] = lmax[i + 4];
    end
    return r;
  endfunction

  // Build a mask from a random run of 1-3 byte chars covering the block.
  function automatic logic [MaskW-1:0] well_formed_mask();
    logic [MaskW-1:0] m;
    int               pos;
    int               sz;
    m   = '0;
    pos = 0;
    while (pos < BlockBytes) begin
      sz = $urandom_range(1, 3);
      for (int j = 1; j < sz; j++) begin
        if (pos + j < BlockBytes) begin
          m[pos + j - 1] = 1'b1;
        end
      end
      pos += sz;
    end
    return m;
  endfunction

  // Offer one mask after a random gap and hold it until the block takes it.
  task automatic send_mask(input logic [MaskW-1:0] m);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cont_mask <= m;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_entries.push_back(predict_entry(m));
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s: expected %h, got %h", field, want, got);
      end
    end
  endtask

  // Edge masks, the error runs, the full-width char patterns, the trailing
  // three-byte char at byte 13, the lane cap, and a walking continuation bit.
  task automatic test_directed();
    send_mask(15'h0000);
    send_mask(15'h7FFF);
    send_mask(15'h5555);
    send_mask(15'h2AAA);
    send_mask(15'h36DB);
    send_mask(15'h6ADB);
    send_mask(15'h0007);
    send_mask(15'h7000);
    send_mask(15'h6000);
    for (int b = 0; b < MaskW; b++) begin
      send_mask(MaskW'(1) << b);
    end
  endtask

  // Mostly well-formed blocks, plus raw noise and blocks with a planted
  // three-in-a-row; switch between idling and back-to-back every few dozen.
  task automatic test_random(input int count);
    logic [MaskW-1:0] m;
    int               pick;
    int               k;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        m = well_formed_mask();
      end else if (pick < 9) begin
        m = MaskW'($urandom);
      end else begin
        m = well_formed_mask();
        k = $urandom_range(0, 12);
        m[k +: 3] = 3'b111;
      end
      send_mask(m);
    end
    calm = 1'b0;
  endtask

  // Stop feeding until every outstanding entry has come back, then resume.
  task automatic test_drain_pause();
    for (int n = 0; n < 10; n++) begin
      send_mask(well_formed_mask());
    end
    in_ch.valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    for (int n = 0; n < 10; n++) begin
      send_mask(well_formed_mask());
    end
  endtask

  // Receiver: drop ready for a random stall before each item.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (res_ch.valid !== 1'b1);
    end
  end

  // Check every accepted entry against the oldest prediction.
  always @(posedge clk_i) begin : check_entries
    res_t want;
    if (rst_ni === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected entry with no prediction waiting");
        end
      end else begin
        want = pending_entries.pop_front();
        compare_field("pattern_ok", 64'(want.pattern_ok), 64'(res_ch.pattern_ok));
        compare_field("pair_shuffle_low", want.pair_shuffle_low,
                      res_ch.pair_shuffle_low);
        compare_field("pair_shuffle_high", want.pair_shuffle_high,
                      res_ch.pair_shuffle_high);
        compare_field("third_shuffle", want.third_shuffle, res_ch.third_shuffle);
        compare_field("source_step", 64'(want.source_step), 64'(res_ch.source_step));
        compare_field("dest_step", 64'(want.dest_step), 64'(res_ch.dest_step));
        compare_field("header_low", want.header_low, res_ch.header_low);
        compare_field("header_high", want.header_high, res_ch.header_high);
        compare_field("lane_max_low", want.lane_max_low, res_ch.lane_max_low);
        compare_field("lane_max_high", want.lane_max_high, res_ch.lane_max_high);
      end
    end
  end

  // Hard stop: far beyond the slowest correct run of all items.
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    mismatches = 0;
    calm       = 1'b0;
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.cont_mask <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_drain_pause();
    test_random(600);
    // Release the input, drain what is still in flight, then allow the
    // pipeline depth again so a stray extra entry would show up.
    in_ch.valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
